FILE: rtl/kll_pkg.sv
// Shared types and constants for the keyword language lexer.
// Holds the transfer payload structs, token and error codes, and the keyword table.
// No dependencies.
package kll_pkg;

    localparam int COLUMN_BITS_DEF = 16;
    localparam int LINE_BITS_DEF   = 16;
    localparam int POS_MAX_W       = 32;   // widest counter the parameters allow
    localparam int TOK_POS_W       = 16;   // width of reported positions
    localparam int WORD_BYTES      = 7;    // identifier bytes kept for keyword compare
    localparam int WORD_W          = 8 * WORD_BYTES;
    localparam int WORD_LEN_W      = 4;    // length saturates at WORD_BYTES + 1
    localparam int KW_COUNT        = 14;
    localparam int OUT_DEPTH       = 4;    // result queue entries

    // Character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;

    typedef enum logic [5:0] {
        K_EOF     = 6'd0,
        K_ERROR   = 6'd1,
        K_INT     = 6'd2,
        K_FLOAT   = 6'd3,
        K_IDENT   = 6'd4,
        K_STRING  = 6'd5,
        K_SET     = 6'd6,
        K_PRINT   = 6'd7,
        K_WHILE   = 6'd8,
        K_DO      = 6'd9,
        K_END     = 6'd10,
        K_AND     = 6'd11,
        K_OR      = 6'd12,
        K_IF      = 6'd13,
        K_THEN    = 6'd14,
        K_ELSE    = 6'd15,
        K_ENDIF   = 6'd16,
        K_PROGRAM = 6'd17,
        K_FOR     = 6'd18,
        K_TO      = 6'd19,
        K_PLUS    = 6'd20,
        K_MINUS   = 6'd21,
        K_STAR    = 6'd22,
        K_SLASH   = 6'd23,
        K_PERCENT = 6'd24,
        K_ASSIGN  = 6'd25,
        K_EQ      = 6'd26,
        K_LPAREN  = 6'd27,
        K_RPAREN  = 6'd28,
        K_COMMA   = 6'd29,
        K_LT      = 6'd30,
        K_LE      = 6'd31,
        K_GT      = 6'd32,
        K_GE      = 6'd33,
        K_NE      = 6'd34
    } kind_t;

    typedef enum logic [2:0] {
        R_NONE          = 3'd0,
        R_MISSING_DIGIT = 3'd1,
        R_LONE_BANG     = 3'd2,
        R_UNKNOWN_CHAR  = 3'd3,
        R_OPEN_STRING   = 3'd4
    } reason_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_marker;
    } char_item_t;

    typedef struct packed {
        kind_t                  token_kind;
        reason_t                error_reason;
        logic [TOK_POS_W-1:0]   start_column;
        logic [TOK_POS_W-1:0]   start_line;
        logic                   last_of_run;
    } token_item_t;

    // Keyword text, first byte in the low byte, in token-code order from K_SET
    localparam logic [WORD_W-1:0] KW_TEXT [KW_COUNT] = '{
        56'h00000000746573,     // set
        56'h0000746E697270,     // print
        56'h0000656C696877,     // while
        56'h00000000006F64,     // do
        56'h00000000646E65,     // end
        56'h00000000646E61,     // and
        56'h0000000000726F,     // or
        56'h00000000006669,     // if
        56'h0000006E656874,     // then
        56'h00000065736C65,     // else
        56'h00006669646E65,     // endif
        56'h6D6172676F7270,     // program
        56'h00000000726F66,     // for
        56'h00000000006F74      // to
    };

    localparam logic [WORD_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd5, 4'd2, 4'd3, 4'd3, 4'd2,
        4'd2, 4'd4, 4'd4, 4'd5, 4'd7, 4'd3, 4'd2
    };

    // Compare a collected word against every keyword in parallel
    function automatic kind_t kw_lookup(input logic [WORD_W-1:0] chars,
                                        input logic [WORD_LEN_W-1:0] len);
        kind_t k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == KW_LEN[i] && chars == KW_TEXT[i]) begin
                k = kind_t'(6'(int'(K_SET) + i));
            end
        end
        return k;
    endfunction

endpackage

FILE: rtl/keyword_language_lexer.sv
// Keyword language lexer: one character or end marker in per transfer, tokens out.
// Input register, combinational scan step, four-entry token queue.
// Depends on kll_pkg.
//
// Usage: feed one byte per s_ transfer, or an end marker to close the stream
// and get an eof token; the block takes one input transfer per clock unless the
// token queue backs up. Each input produces zero, one or two tokens; a token
// that needs lookahead (number, word, '=', '<', '>', '!') is closed by the next
// byte it cannot take, blanks included, which may start or be a token itself,
// so one byte can yield two tokens, the second flagged last_of_run (the last
// token of any input always carries last_of_run). The scan step reads the input
// register and writes the token queue, which feeds m_ directly. The queue drains
// one token per cycle while m_ready is high, so the m_ side, not the scan logic,
// sets the rate once the text averages more than one token per byte: inputs
// stall while the queue holds more than two tokens. Text between paired '#'
// marks is dropped but still counted in column and line. Columns count from 1
// after each newline, lines from 0; both counters saturate at all ones, and the
// reported positions are their low 16 bits.
module keyword_language_lexer
    import kll_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  char_item_t  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output token_item_t m_data
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INT, S_DOT, S_FRAC, S_ZERO, S_HEXNEED, S_HEX,
        S_WORD, S_STR, S_EQ, S_LT, S_GT, S_BANG
    } mode_t;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    mode_t                  mode_reg, mode_next;
    logic                   comment_reg, comment_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] tcol_reg, tcol_next;
    logic [LINE_BITS-1:0]   tline_reg, tline_next;
    logic [WORD_W-1:0]      word_reg, word_next;
    logic [WORD_LEN_W-1:0]  wlen_reg, wlen_next;

    // Input register
    logic       in_valid_reg;
    char_item_t in_data_reg;

    // Token queue
    token_item_t          queue_reg [OUT_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    logic proc_go;
    logic pop;

    // Room for two more tokens whatever the m_ side does this cycle
    assign proc_go = in_valid_reg && (count_reg <= CNT_W'(OUT_DEPTH - 2));
    assign s_ready = !in_valid_reg || proc_go;
    assign m_valid = (count_reg != '0);
    assign m_data  = queue_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // ---------------------------------------------------------------
    // Scan step
    // ---------------------------------------------------------------
    logic [7:0] ch;
    logic       is_end;
    logic       is_digit, is_hex, is_letter, is_word_ch, is_blank;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [LINE_BITS-1:0]   line_inc;

    // tok0 comes from closing the pending token, tok1 from the current byte
    logic    v0, v1;
    kind_t   k0, k1;
    reason_t r0, r1;
    logic    absorbed;

    logic [POS_MAX_W-1:0] tcol_ext, tline_ext, ncol_ext, nline_ext;
    token_item_t tok0, tok1, first_tok;
    logic [1:0]  push_cnt;

    assign ch     = in_data_reg.char_code;
    assign is_end = in_data_reg.end_marker;

    assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_hex     = is_digit || ((ch >= CH_LO_A) && (ch <= CH_LO_F));
    assign is_letter  = ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ||
                        ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
    assign is_word_ch = is_letter || is_digit || (ch == CH_UNDER);
    assign is_blank   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);

    assign col_inc  = (&col_reg)  ? col_reg  : col_reg + 1'b1;
    assign line_inc = (&line_reg) ? line_reg : line_reg + 1'b1;

    always_comb begin
        mode_next    = mode_reg;
        comment_next = comment_reg;
        col_next     = col_inc;
        line_next    = line_reg;
        tcol_next    = tcol_reg;
        tline_next   = tline_reg;
        word_next    = word_reg;
        wlen_next    = wlen_reg;
        v0 = 1'b0; k0 = K_EOF; r0 = R_NONE;
        v1 = 1'b0; k1 = K_EOF; r1 = R_NONE;
        absorbed = 1'b0;

        if (is_end) begin
            // Close whatever is pending, then report eof at the new column
            v0 = (mode_reg != S_IDLE);
            case (mode_reg)
                S_INT, S_ZERO, S_HEX: k0 = K_INT;
                S_FRAC:               k0 = K_FLOAT;
                S_DOT, S_HEXNEED: begin
                    k0 = K_ERROR; r0 = R_MISSING_DIGIT;
                end
                S_WORD:               k0 = kw_lookup(word_reg, wlen_reg);
                S_STR: begin
                    k0 = K_ERROR; r0 = R_OPEN_STRING;
                end
                S_EQ:                 k0 = K_ASSIGN;
                S_LT:                 k0 = K_LT;
                S_GT:                 k0 = K_GT;
                S_BANG: begin
                    k0 = K_ERROR; r0 = R_LONE_BANG;
                end
                default:              k0 = K_EOF;
            endcase
            tcol_next    = col_inc;
            tline_next   = line_reg;
            v1           = 1'b1;
            k1           = K_EOF;
            mode_next    = S_IDLE;
            comment_next = 1'b0;
            word_next    = '0;
            wlen_next    = '0;
        end else begin
            if (ch == CH_NL) begin
                line_next = line_inc;
                col_next  = '0;
            end
            if (comment_reg) begin
                if (ch == CH_HASH) begin
                    comment_next = 1'b0;
                end
            end else if (ch == CH_HASH) begin
                comment_next = 1'b1;
            end else begin
                // Offer the byte to the pending token first
                case (mode_reg)
                    S_INT: begin
                        if (is_digit) begin
                            absorbed = 1'b1;
                        end else if (ch == CH_DOT) begin
                            absorbed = 1'b1; mode_next = S_DOT;
                        end else begin
                            v0 = 1'b1; k0 = K_INT;
                        end
                    end
                    S_DOT: begin
                        if (is_digit) begin
                            absorbed = 1'b1; mode_next = S_FRAC;
                        end else begin
                            v0 = 1'b1; k0 = K_ERROR; r0 = R_MISSING_DIGIT;
                        end
                    end
                    S_FRAC: begin
                        if (is_digit) begin
                            absorbed = 1'b1;
                        end else begin
                            v0 = 1'b1; k0 = K_FLOAT;
                        end
                    end
                    S_ZERO: begin
                        if (ch == CH_LO_X) begin
                            absorbed = 1'b1; mode_next = S_HEXNEED;
                        end else if (ch == CH_DOT) begin
                            absorbed = 1'b1; mode_next = S_DOT;
                        end else begin
                            v0 = 1'b1; k0 = K_INT;
                        end
                    end
                    S_HEXNEED: begin
                        if (is_hex) begin
                            absorbed = 1'b1; mode_next = S_HEX;
                        end else begin
                            v0 = 1'b1; k0 = K_ERROR; r0 = R_MISSING_DIGIT;
                        end
                    end
                    S_HEX: begin
                        if (is_hex) begin
                            absorbed = 1'b1;
                        end else begin
                            v0 = 1'b1; k0 = K_INT;
                        end
                    end
                    S_WORD: begin
                        if (is_word_ch) begin
                            absorbed = 1'b1;
                            for (int i = 0; i < WORD_BYTES; i++) begin
                                if (wlen_reg == WORD_LEN_W'(i)) begin
                                    word_next[8*i +: 8] = ch;
                                end
                            end
                            if (wlen_reg <= WORD_LEN_W'(WORD_BYTES)) begin
                                wlen_next = wlen_reg + 1'b1;
                            end
                        end else begin
                            v0 = 1'b1; k0 = kw_lookup(word_reg, wlen_reg);
                        end
                    end
                    S_STR: begin
                        // Every byte belongs to the string; the quote closes it
                        absorbed = 1'b1;
                        if (ch == CH_QUOTE) begin
                            v0 = 1'b1; k0 = K_STRING; mode_next = S_IDLE;
                        end
                    end
                    S_EQ, S_LT, S_GT, S_BANG: begin
                        if (ch == CH_EQUAL) begin
                            absorbed  = 1'b1;
                            v0        = 1'b1;
                            mode_next = S_IDLE;
                            case (mode_reg)
                                S_EQ:    k0 = K_EQ;
                                S_LT:    k0 = K_LE;
                                S_GT:    k0 = K_GE;
                                default: k0 = K_NE;
                            endcase
                        end else begin
                            v0 = 1'b1;
                            case (mode_reg)
                                S_EQ:    k0 = K_ASSIGN;
                                S_LT:    k0 = K_LT;
                                S_GT:    k0 = K_GT;
                                default: begin
                                    k0 = K_ERROR; r0 = R_LONE_BANG;
                                end
                            endcase
                        end
                    end
                    default: absorbed = 1'b0;
                endcase

                // Start a new token with the byte the pending one refused
                if (!absorbed) begin
                    mode_next = S_IDLE;
                    if (!is_blank) begin
                        tcol_next  = col_next;
                        tline_next = line_next;
                        if (is_digit && ch >= CH_ONE) begin
                            mode_next = S_INT;
                        end else if (ch == CH_ZERO) begin
                            mode_next = S_ZERO;
                        end else if (is_letter) begin
                            mode_next = S_WORD;
                            word_next = WORD_W'(ch);
                            wlen_next = WORD_LEN_W'(1);
                        end else begin
                            case (ch)
                                CH_QUOTE:   mode_next = S_STR;
                                CH_EQUAL:   mode_next = S_EQ;
                                CH_LT:      mode_next = S_LT;
                                CH_GT:      mode_next = S_GT;
                                CH_BANG:    mode_next = S_BANG;
                                CH_PLUS: begin
                                    v1 = 1'b1; k1 = K_PLUS;
                                end
                                CH_MINUS: begin
                                    v1 = 1'b1; k1 = K_MINUS;
                                end
                                CH_STAR: begin
                                    v1 = 1'b1; k1 = K_STAR;
                                end
                                CH_SLASH: begin
                                    v1 = 1'b1; k1 = K_SLASH;
                                end
                                CH_PERCENT: begin
                                    v1 = 1'b1; k1 = K_PERCENT;
                                end
                                CH_LPAREN: begin
                                    v1 = 1'b1; k1 = K_LPAREN;
                                end
                                CH_RPAREN: begin
                                    v1 = 1'b1; k1 = K_RPAREN;
                                end
                                CH_COMMA: begin
                                    v1 = 1'b1; k1 = K_COMMA;
                                end
                                default: begin
                                    v1 = 1'b1; k1 = K_ERROR; r1 = R_UNKNOWN_CHAR;
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Token assembly: closing token carries the old start position,
    // the new one the position just marked
    // ---------------------------------------------------------------
    assign tcol_ext  = POS_MAX_W'(tcol_reg);
    assign tline_ext = POS_MAX_W'(tline_reg);
    assign ncol_ext  = POS_MAX_W'(tcol_next);
    assign nline_ext = POS_MAX_W'(tline_next);

    always_comb begin
        tok0.token_kind   = k0;
        tok0.error_reason = r0;
        tok0.start_column = tcol_ext[TOK_POS_W-1:0];
        tok0.start_line   = tline_ext[TOK_POS_W-1:0];
        tok0.last_of_run  = !v1;
        tok1.token_kind   = k1;
        tok1.error_reason = r1;
        tok1.start_column = ncol_ext[TOK_POS_W-1:0];
        tok1.start_line   = nline_ext[TOK_POS_W-1:0];
        tok1.last_of_run  = 1'b1;
        first_tok = v0 ? tok0 : tok1;
        push_cnt  = proc_go ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;
    end

    // ---------------------------------------------------------------
    // Control and scan state
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= S_IDLE;
            comment_reg  <= 1'b0;
            col_reg      <= '0;
            line_reg     <= '0;
            tcol_reg     <= '0;
            tline_reg    <= '0;
            word_reg     <= '0;
            wlen_reg     <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc_go) begin
                mode_reg    <= mode_next;
                comment_reg <= comment_next;
                col_reg     <= col_next;
                line_reg    <= line_next;
                tcol_reg    <= tcol_next;
                tline_reg   <= tline_next;
                word_reg    <= word_next;
                wlen_reg    <= wlen_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
        end
    end

    // Payload: input byte and queued tokens
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (push_cnt != 2'd0) begin
            queue_reg[wr_ptr_reg] <= first_tok;
        end
        if (push_cnt == 2'd2) begin
            queue_reg[wr_ptr_reg + 1'b1] <= tok1;
        end
    end

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(OUT_DEPTH))
        else $error("token queue overflow");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_go && is_end) |=> (mode_reg == S_IDLE && !comment_reg))
        else $error("end marker left scan state open");

    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_go && is_end) |-> (push_cnt != 2'd0))
        else $error("end marker gave no eof token");

    a_comment_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_go && comment_reg && !is_end) |-> (push_cnt == 2'd0))
        else $error("token emitted inside comment");

    a_reason_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.token_kind == K_ERROR) == (m_data.error_reason != R_NONE)))
        else $error("error reason does not match token kind");
`endif

endmodule

FILE: bench/lexer_token_checker.sv
`timescale 1ns / 100ps
// Token checker for the keyword language lexer bench: predicts the tokens of every
// accepted character transfer and compares them, in order, with the m_ transfers.
// Depends on kll_pkg.
module lexer_token_checker
    import kll_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  char_item_t  s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  token_item_t m_data,
    output int          mismatch_count,
    output int          tokens_owed
);

    localparam int MAX_REPORTS = 60;

    typedef enum logic [3:0] {
        SC_IDLE, SC_INT, SC_DOT, SC_FRAC, SC_ZERO, SC_HEXNEED, SC_HEX,
        SC_WORD, SC_STR, SC_EQ, SC_LT, SC_GT, SC_BANG
    } scan_t;

    string kw_spelling [KW_COUNT] = '{"set", "print", "while", "do", "end", "and", "or",
                                      "if", "then", "else", "endif", "program", "for", "to"};
    kind_t kw_code [KW_COUNT] = '{K_SET, K_PRINT, K_WHILE, K_DO, K_END, K_AND, K_OR,
                                  K_IF, K_THEN, K_ELSE, K_ENDIF, K_PROGRAM, K_FOR, K_TO};

    scan_t                  mode;
    logic                   in_comment;
    logic [COLUMN_BITS-1:0] col_cnt;
    logic [LINE_BITS-1:0]   line_cnt;
    logic [COLUMN_BITS-1:0] tok_col;
    logic [LINE_BITS-1:0]   tok_line;
    logic [WORD_W-1:0]      word_bytes;
    logic [WORD_LEN_W-1:0]  word_len;

    token_item_t step_out [2];
    int          step_n;
    token_item_t owed_tokens [$];
    int          errors = 0;

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return is_digit(c) || (c >= CH_LO_A && c <= CH_LO_F);
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic void clear_scanner();
        mode       = SC_IDLE;
        in_comment = 1'b0;
        col_cnt    = '0;
        line_cnt   = '0;
        tok_col    = '0;
        tok_line   = '0;
        word_bytes = '0;
        word_len   = '0;
    endfunction

    function automatic void push_token(kind_t k, reason_t r);
        step_out[step_n].token_kind   = k;
        step_out[step_n].error_reason = r;
        step_out[step_n].start_column = TOK_POS_W'(tok_col);
        step_out[step_n].start_line   = TOK_POS_W'(tok_line);
        step_out[step_n].last_of_run  = 1'b0;
        step_n++;
    endfunction

    function automatic kind_t word_token();
        logic [WORD_W-1:0] spelled;
        kind_t             k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            spelled = '0;
            for (int j = 0; j < kw_spelling[i].len(); j++) begin
                spelled[8*j +: 8] = kw_spelling[i][j];
            end
            if (int'(word_len) == kw_spelling[i].len() && spelled == word_bytes) begin
                k = kw_code[i];
            end
        end
        return k;
    endfunction

    function automatic void open_token(logic [7:0] c);
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL) return;
        tok_col  = col_cnt;
        tok_line = line_cnt;
        if (c >= CH_ONE && c <= CH_NINE) begin
            mode = SC_INT;
        end else if (c == CH_ZERO) begin
            mode = SC_ZERO;
        end else if (is_letter(c)) begin
            word_bytes      = '0;
            word_bytes[7:0] = c;
            word_len        = WORD_LEN_W'(1);
            mode            = SC_WORD;
        end else begin
            case (c)
                CH_QUOTE:   mode = SC_STR;
                CH_EQUAL:   mode = SC_EQ;
                CH_LT:      mode = SC_LT;
                CH_GT:      mode = SC_GT;
                CH_BANG:    mode = SC_BANG;
                CH_PLUS:    push_token(K_PLUS, R_NONE);
                CH_MINUS:   push_token(K_MINUS, R_NONE);
                CH_STAR:    push_token(K_STAR, R_NONE);
                CH_SLASH:   push_token(K_SLASH, R_NONE);
                CH_PERCENT: push_token(K_PERCENT, R_NONE);
                CH_LPAREN:  push_token(K_LPAREN, R_NONE);
                CH_RPAREN:  push_token(K_RPAREN, R_NONE);
                CH_COMMA:   push_token(K_COMMA, R_NONE);
                default:    push_token(K_ERROR, R_UNKNOWN_CHAR);
            endcase
        end
    endfunction

    // Return 1 when the pending token swallows c; otherwise close it and go idle.
    function automatic bit extend_token(logic [7:0] c);
        case (mode)
            SC_INT: begin
                if (is_digit(c)) return 1'b1;
                if (c == CH_DOT) begin
                    mode = SC_DOT;
                    return 1'b1;
                end
                push_token(K_INT, R_NONE);
            end
            SC_DOT: begin
                if (is_digit(c)) begin
                    mode = SC_FRAC;
                    return 1'b1;
                end
                push_token(K_ERROR, R_MISSING_DIGIT);
            end
            SC_FRAC: begin
                if (is_digit(c)) return 1'b1;
                push_token(K_FLOAT, R_NONE);
            end
            SC_ZERO: begin
                if (c == CH_LO_X) begin
                    mode = SC_HEXNEED;
                    return 1'b1;
                end
                if (c == CH_DOT) begin
                    mode = SC_DOT;
                    return 1'b1;
                end
                push_token(K_INT, R_NONE);
            end
            SC_HEXNEED: begin
                if (is_hex(c)) begin
                    mode = SC_HEX;
                    return 1'b1;
                end
                push_token(K_ERROR, R_MISSING_DIGIT);
            end
            SC_HEX: begin
                if (is_hex(c)) return 1'b1;
                push_token(K_INT, R_NONE);
            end
            SC_WORD: begin
                if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
                    if (word_len < WORD_BYTES) word_bytes[8*word_len +: 8] = c;
                    if (word_len < WORD_BYTES + 1) word_len = word_len + 1'b1;
                    return 1'b1;
                end
                push_token(word_token(), R_NONE);
            end
            SC_STR: begin
                if (c == CH_QUOTE) begin
                    push_token(K_STRING, R_NONE);
                    mode = SC_IDLE;
                end
                return 1'b1;
            end
            SC_EQ, SC_LT, SC_GT, SC_BANG: begin
                if (c == CH_EQUAL) begin
                    case (mode)
                        SC_EQ:   push_token(K_EQ, R_NONE);
                        SC_LT:   push_token(K_LE, R_NONE);
                        SC_GT:   push_token(K_GE, R_NONE);
                        default: push_token(K_NE, R_NONE);
                    endcase
                    mode = SC_IDLE;
                    return 1'b1;
                end
                case (mode)
                    SC_EQ:   push_token(K_ASSIGN, R_NONE);
                    SC_LT:   push_token(K_LT, R_NONE);
                    SC_GT:   push_token(K_GT, R_NONE);
                    default: push_token(K_ERROR, R_LONE_BANG);
                endcase
            end
            default: ;
        endcase
        mode = SC_IDLE;
        return 1'b0;
    endfunction

    function automatic void close_at_end();
        case (mode)
            SC_INT, SC_ZERO, SC_HEX: push_token(K_INT, R_NONE);
            SC_FRAC:                 push_token(K_FLOAT, R_NONE);
            SC_DOT, SC_HEXNEED:      push_token(K_ERROR, R_MISSING_DIGIT);
            SC_WORD:                 push_token(word_token(), R_NONE);
            SC_STR:                  push_token(K_ERROR, R_OPEN_STRING);
            SC_EQ:                   push_token(K_ASSIGN, R_NONE);
            SC_LT:                   push_token(K_LT, R_NONE);
            SC_GT:                   push_token(K_GT, R_NONE);
            SC_BANG:                 push_token(K_ERROR, R_LONE_BANG);
            default: ;
        endcase
    endfunction

    function automatic void scan_item(char_item_t it);
        logic [7:0] c;
        c      = it.char_code;
        step_n = 0;
        if (col_cnt != '1) col_cnt = col_cnt + 1'b1;
        if (it.end_marker) begin
            close_at_end();
            tok_col    = col_cnt;
            tok_line   = line_cnt;
            push_token(K_EOF, R_NONE);
            mode       = SC_IDLE;
            in_comment = 1'b0;
            word_bytes = '0;
            word_len   = '0;
        end else begin
            if (c == CH_NL) begin
                if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
                col_cnt = '0;
            end
            if (in_comment) begin
                if (c == CH_HASH) in_comment = 1'b0;
            end else if (c == CH_HASH) begin
                in_comment = 1'b1;
            end else if (mode == SC_IDLE) begin
                open_token(c);
            end else if (!extend_token(c)) begin
                open_token(c);
            end
        end
        if (step_n > 0) step_out[step_n-1].last_of_run = 1'b1;
        for (int i = 0; i < step_n; i++) owed_tokens.push_back(step_out[i]);
    endfunction

    function automatic void flag_field(string field, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= MAX_REPORTS) $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function automatic void check_token(token_item_t got);
        token_item_t want;
        if (owed_tokens.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $error("token kind %0d at line %0d column %0d arrived with none expected",
                       got.token_kind, got.start_line, got.start_column);
            end
            return;
        end
        want = owed_tokens.pop_front();
        if (got.token_kind !== want.token_kind)
            flag_field("token_kind", want.token_kind, got.token_kind);
        if (got.error_reason !== want.error_reason)
            flag_field("error_reason", want.error_reason, got.error_reason);
        if (got.start_column !== want.start_column)
            flag_field("start_column", want.start_column, got.start_column);
        if (got.start_line !== want.start_line)
            flag_field("start_line", want.start_line, got.start_line);
        if (got.last_of_run !== want.last_of_run)
            flag_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    // Compare before predicting: a token leaving now never stems from a
    // character accepted at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_scanner();
            owed_tokens.delete();
        end else begin
            if (m_valid && m_ready) check_token(m_data);
            if (s_valid && s_ready) scan_item(s_data);
        end
        mismatch_count <= errors;
        tokens_owed    <= owed_tokens.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Top of the keyword language lexer bench: clock, reset, character stimulus and verdict.
// Depends on kll_pkg, keyword_language_lexer and lexer_token_checker.
module tb;
    import kll_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 5000;   // cycles without any transfer
    localparam int HOLD_CYCLES  = 300;    // long m_ready hold-off
    localparam int PHASE_ITEMS  = 170;
    localparam int TAIL_CYCLES  = 20;
    localparam int OP_COUNT     = 15;
    localparam int SINGLE_OPS   = 8;      // leading entries of operator_text

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    char_item_t  s_data  = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    token_item_t m_data;

    int mismatches;
    int owed;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int counted_items = 0;
    int hold_asks     = 0;
    int quiet_cycles  = 0;

    string keyword_text [KW_COUNT] = '{"set", "print", "while", "do", "end", "and", "or",
                                       "if", "then", "else", "endif", "program", "for", "to"};
    string operator_text [OP_COUNT] = '{"+", "-", "*", "/", "%", "(", ")", ",",
                                        "=", "==", "<", "<=", ">", ">=", "!="};

    always #(HALF_PERIOD) aclk = ~aclk;

    keyword_language_lexer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    lexer_token_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatches),
        .tokens_owed    (owed)
    );

    // Watchdog: count cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Token sink: drop m_ready at the current idle rate; on request hold it low
    // for a long stretch, counted here, so the block backs up into s_ready.
    initial begin
        int hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one character transfer; insert random idle cycles first, then hold
    // valid and payload steady until the handshake completes.
    task automatic put_item(input logic [7:0] c, input logic e);
        char_item_t item;
        item.char_code  = c;
        item.end_marker = e;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        counted_items++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) put_item(t[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'(CH_LO_A + $urandom_range(25))
                                 : 8'(CH_UP_A + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_hex();
        return ($urandom_range(15) < 10) ? rand_digit() : 8'(CH_LO_A + $urandom_range(5));
    endfunction

    // One random lexeme, mostly well formed, followed by an optional blank.
    task automatic random_fragment();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 12) begin
            send_text(keyword_text[$urandom_range(KW_COUNT-1)]);
        end else if (pick < 26) begin
            // identifier; sometimes a keyword with a tail, up to past 7 bytes
            if ($urandom_range(3) == 0) send_text(keyword_text[$urandom_range(KW_COUNT-1)]);
            else put_item(rand_letter(), 1'b0);
            repeat ($urandom_range(9)) begin
                case ($urandom_range(3))
                    0:       put_item(rand_digit(), 1'b0);
                    1:       put_item(CH_UNDER, 1'b0);
                    default: put_item(rand_letter(), 1'b0);
                endcase
            end
        end else if (pick < 40) begin
            case ($urandom_range(3))
                0, 1: begin
                    put_item(8'(CH_ONE + $urandom_range(8)), 1'b0);
                    repeat ($urandom_range(4)) put_item(rand_digit(), 1'b0);
                    if ($urandom_range(1)) begin
                        put_item(CH_DOT, 1'b0);
                        repeat (1 + $urandom_range(2)) put_item(rand_digit(), 1'b0);
                    end
                end
                2: begin
                    // leading zero: alone, before digits, or as a float
                    put_item(CH_ZERO, 1'b0);
                    if ($urandom_range(1)) put_item(CH_DOT, 1'b0);
                    repeat ($urandom_range(3)) put_item(rand_digit(), 1'b0);
                end
                default: begin
                    send_text("0x");
                    repeat (1 + $urandom_range(3)) put_item(rand_hex(), 1'b0);
                end
            endcase
        end else if (pick < 50) begin
            put_item(CH_QUOTE, 1'b0);
            repeat ($urandom_range(6)) begin
                case ($urandom_range(3))
                    0:       put_item(CH_SPACE, 1'b0);
                    1:       put_item(CH_NL, 1'b0);
                    2:       put_item(rand_digit(), 1'b0);
                    default: put_item(rand_letter(), 1'b0);
                endcase
            end
            if ($urandom_range(9) != 0) put_item(CH_QUOTE, 1'b0);
        end else if (pick < 70) begin
            send_text(operator_text[$urandom_range(OP_COUNT-1)]);
        end else if (pick < 78) begin
            // hidden text: any byte but the closing mark
            put_item(CH_HASH, 1'b0);
            repeat ($urandom_range(5)) begin
                do c = 8'($urandom_range(255)); while (c == CH_HASH);
                put_item(c, 1'b0);
            end
            put_item(CH_HASH, 1'b0);
        end else if (pick < 87) begin
            // broken sequences: dot or hex prefix without a digit, bang alone
            case ($urandom_range(2))
                0: begin
                    send_text("1.");
                    put_item(rand_letter(), 1'b0);
                end
                1: begin
                    send_text("0x");
                    put_item(8'(CH_LO_F + 1 + $urandom_range(19)), 1'b0);
                end
                default: begin
                    put_item(CH_BANG, 1'b0);
                    put_item($urandom_range(1) ? rand_letter() : CH_SPACE, 1'b0);
                end
            endcase
        end else if (pick < 97) begin
            put_item(8'($urandom_range(255)), 1'b0);
        end else begin
            put_item(8'($urandom_range(255)), 1'b1);
        end
        case ($urandom_range(5))
            2, 3:    put_item(CH_SPACE, 1'b0);
            4:       put_item(CH_TAB, 1'b0);
            5:       put_item(CH_NL, 1'b0);
            default: ;
        endcase
    endtask

    task automatic random_run(input int target);
        while (counted_items < target) random_fragment();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase 1: sender idles lightly, sink idles heavily.
        send_idle_pct = 19;
        recv_idle_pct = 49;

        // Directed: missing digits, lone bang, leading zero, keyword vs long word,
        // two-character operators, string across a newline with a hidden quote.
        send_text("0x 1.+!a 07 1.5 0x1f endif program programs a==b!=c<=d>=e ");
        send_text("\"a\n#\"#b\" _");
        put_item(8'hFF, 1'b0);
        put_item(8'h00, 1'b0);
        // back-to-back end markers give one eof each
        put_item(8'hA5, 1'b1);
        put_item(8'h5A, 1'b1);
        // string left open at the end, then a pending '<' closed by the end
        send_text("\"ab");
        put_item(8'h00, 1'b1);
        send_text("x<");
        put_item(8'hFF, 1'b1);

        counted_items = 0;
        random_run(PHASE_ITEMS);

        // Phase 2: swap the idle rates.
        send_idle_pct = 49;
        recv_idle_pct = 19;
        random_run(2 * PHASE_ITEMS);

        // Phase 3: no idling. Hold the sink off and keep offering single-byte
        // operators so the token queue fills and s_ready drops.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks++;
        repeat (60) send_text(operator_text[$urandom_range(SINGLE_OPS-1)]);
        random_run(3 * PHASE_ITEMS);

        // Close with a word and a pending int ended by the end marker.
        send_text("x1 7");
        put_item(8'h3C, 1'b1);

        s_valid <= 1'b0;

        // Drain: wait for every owed token, bounded, then let the pipe settle.
        @(posedge aclk);
        for (int n = 0; n < STALL_LIMIT && owed != 0; n++) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && owed == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
